// ===== hw/rtl/vrtf_pkg.sv =====
package vrtf_pkg;

   // coordinate sums before wrapping stay below 4096
   localparam int unsigned COORD_W    = 12;
   // compare-subtract steps for a store dimension of at least 64
   localparam int unsigned WRAP_STEPS = 6;
   localparam int unsigned HALF_W     = 16;
   localparam int unsigned CSR_W      = 10;

   localparam logic [2:0] FUNC_START_UP   = 3'd0;
   localparam logic [2:0] FUNC_WRITE      = 3'd1;
   localparam logic [2:0] FUNC_START_DOWN = 3'd2;
   localparam logic [2:0] FUNC_READ       = 3'd3;
   localparam logic [2:0] FUNC_TEXEL      = 3'd4;

   localparam logic [2:0] CSR_TEX_PAGE_X  = 3'd0;
   localparam logic [2:0] CSR_TEX_PAGE_Y  = 3'd1;
   localparam logic [2:0] CSR_PALETTE_X   = 3'd2;
   localparam logic [2:0] CSR_PALETTE_Y   = 3'd3;
   localparam logic [2:0] CSR_COLOR_DEPTH = 3'd4;

   localparam logic [1:0] DEPTH_4BPP = 2'd0;
   localparam logic [1:0] DEPTH_8BPP = 2'd1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SECOND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [9:0]  x;
      logic [8:0]  y;
      logic [10:0] w;
      logic [9:0]  h;
   } rect_type;

   typedef struct packed {
      logic start;
      logic advance;
   } cur_ctrl_type;

   typedef struct packed {
      logic en;
      logic we;
   } mem_ctrl_type;

   // remainder of a by d through restoring compare-subtract steps
   function automatic logic [COORD_W-1:0] wrap_coord(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W:0] d,
                                                     input int unsigned steps);
      logic [COORD_W+WRAP_STEPS:0] r;
      logic [COORD_W+WRAP_STEPS:0] dk;
      r = {{(WRAP_STEPS+1){1'b0}}, a};
      for (int k = WRAP_STEPS; k >= 0; k--) begin
         dk = {{WRAP_STEPS{1'b0}}, d} << k;
         if ((unsigned'(k) <= steps) && (r >= dk)) begin
            r = r - dk;
         end
      end
      return r[COORD_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/vram_rect_transfer_texel_fetch_top.sv =====
// VRAM store of VRAM_WIDTH x VRAM_HEIGHT halfwords with rectangle upload and
// download and palette or direct texel fetch, all through one single-port
// synchronous memory. After reset the block clears the whole memory, one
// halfword per cycle, over 2**(clog2(VRAM_WIDTH) + clog2(VRAM_HEIGHT)) addresses
// (524288 at the default size); req_ready stays low meanwhile, csr writes are
// taken at any time. Transfer starts, halfword writes and unused codes go to
// the result state at once; word reads and texel fetches pass a second state,
// which reads the upper halfword or, at 4 and 8 bpp, the palette entry. A result
// that is not taken holds the block until rsp_ready. Columns wrap at VRAM_WIDTH
// and rows at VRAM_HEIGHT; both must lie between 64 and 4096.
module vram_rect_transfer_texel_fetch_top
   import vrtf_pkg::*;
#(
   parameter int unsigned VRAM_WIDTH  = 1024,
   parameter int unsigned VRAM_HEIGHT = 512
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_wdata,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_func,
   input  logic [9:0]        req_rect_x,
   input  logic [8:0]        req_rect_y,
   input  logic [10:0]       req_rect_w,
   input  logic [9:0]        req_rect_h,
   input  logic [15:0]       req_pixel_data,
   input  logic [7:0]        req_tex_u,
   input  logic [7:0]        req_tex_v,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_read_word,
   output logic [7:0]        rsp_red,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_blue,
   output logic              rsp_upload_busy,
   output logic              rsp_download_busy
);

   localparam int unsigned COL_W     = $clog2(VRAM_WIDTH);
   localparam int unsigned ROW_W     = $clog2(VRAM_HEIGHT);
   localparam int unsigned ADDR_W    = COL_W + ROW_W;
   localparam int unsigned COL_STEPS = COORD_W - COL_W;
   localparam int unsigned ROW_STEPS = COORD_W - ROW_W;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic [9:0] tpx_ff, tpx_in;
   logic [8:0] tpy_ff, tpy_in;
   logic [9:0] plx_ff, plx_in;
   logic [8:0] ply_ff, ply_in;
   logic [1:0] depth_ff, depth_in;

   logic [2:0]        func_ff, func_in;
   logic [1:0]        u_lo_ff, u_lo_in;
   logic              lo_hit_ff, lo_hit_in;
   logic              hi_hit_ff, hi_hit_in;
   logic [HALF_W-1:0] lo_ff, lo_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [7:0]  rsp_red_ff, rsp_red_in;
   logic [7:0]  rsp_green_ff, rsp_green_in;
   logic [7:0]  rsp_blue_ff, rsp_blue_in;
   logic        rsp_up_ff, rsp_up_in;
   logic        rsp_dn_ff, rsp_dn_in;
   logic        rsp_load;

   logic accept;

   mem_ctrl_type      mem_ctrl;
   logic [ADDR_W-1:0] mem_addr;
   logic [HALF_W-1:0] mem_wdata;
   logic [HALF_W-1:0] mem_rdata;

   cur_ctrl_type     up_ctrl, dn_ctrl;
   rect_type         req_rect;
   logic             up_active, dn_active;
   logic [COL_W-1:0] up_col, dn_col;
   logic [ROW_W-1:0] up_row, dn_row;

   logic [7:0]         u_part;
   logic [7:0]         sel;
   logic [COORD_W-1:0] tex_col_sum, tex_row_sum, pal_col_sum, pal_row_sum;
   logic [COORD_W-1:0] tex_col, tex_row, pal_col, pal_row;

   assign req_rect = '{x: req_rect_x, y: req_rect_y, w: req_rect_w, h: req_rect_h};

   vrtf_cursor #(
      .VRAM_WIDTH  (VRAM_WIDTH),
      .VRAM_HEIGHT (VRAM_HEIGHT)
   ) u_up_cursor (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (up_ctrl),
      .rect   (req_rect),
      .active (up_active),
      .col    (up_col),
      .row    (up_row)
   );

   vrtf_cursor #(
      .VRAM_WIDTH  (VRAM_WIDTH),
      .VRAM_HEIGHT (VRAM_HEIGHT)
   ) u_dn_cursor (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (dn_ctrl),
      .rect   (req_rect),
      .active (dn_active),
      .col    (dn_col),
      .row    (dn_row)
   );

   vrtf_vram #(
      .ADDR_W (ADDR_W)
   ) u_vram (
      .clock (clock),
      .ctrl  (mem_ctrl),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // texel word address, halfword index scaled by the colour depth
   always_comb begin
      unique case (depth_ff)
         DEPTH_4BPP: u_part = {2'b00, req_tex_u[7:2]};
         DEPTH_8BPP: u_part = {1'b0, req_tex_u[7:1]};
         default:    u_part = req_tex_u;
      endcase
   end

   // palette index picked from the texel word
   always_comb begin
      if (depth_ff == DEPTH_4BPP) begin
         unique case (u_lo_ff)
            2'd0:    sel = {4'h0, mem_rdata[3:0]};
            2'd1:    sel = {4'h0, mem_rdata[7:4]};
            2'd2:    sel = {4'h0, mem_rdata[11:8]};
            default: sel = {4'h0, mem_rdata[15:12]};
         endcase
      end else begin
         sel = u_lo_ff[0] ? mem_rdata[15:8] : mem_rdata[7:0];
      end
   end

   assign tex_col_sum = {2'b00, tpx_ff} + {4'h0, u_part};
   assign tex_row_sum = {3'b000, tpy_ff} + {4'h0, req_tex_v};
   assign pal_col_sum = {2'b00, plx_ff} + {4'h0, sel};
   assign pal_row_sum = {3'b000, ply_ff};

   assign tex_col = wrap_coord(tex_col_sum, (COORD_W+1)'(VRAM_WIDTH), COL_STEPS);
   assign tex_row = wrap_coord(tex_row_sum, (COORD_W+1)'(VRAM_HEIGHT), ROW_STEPS);
   assign pal_col = wrap_coord(pal_col_sum, (COORD_W+1)'(VRAM_WIDTH), COL_STEPS);
   assign pal_row = wrap_coord(pal_row_sum, (COORD_W+1)'(VRAM_HEIGHT), ROW_STEPS);

   // configuration registers
   always_comb begin
      tpx_in   = tpx_ff;
      tpy_in   = tpy_ff;
      plx_in   = plx_ff;
      ply_in   = ply_ff;
      depth_in = depth_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TEX_PAGE_X:  tpx_in   = csr_wdata[9:0];
            CSR_TEX_PAGE_Y:  tpy_in   = csr_wdata[8:0];
            CSR_PALETTE_X:   plx_in   = csr_wdata[9:0];
            CSR_PALETTE_Y:   ply_in   = csr_wdata[8:0];
            CSR_COLOR_DEPTH: depth_in = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if ((req_func == FUNC_READ) || (req_func == FUNC_TEXEL)) begin
                  state_in = ST_SECOND;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SECOND: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // memory port, cursors and transaction latches
   always_comb begin
      mem_ctrl     = '0;
      mem_addr     = {dn_row, dn_col};
      mem_wdata    = req_pixel_data;
      up_ctrl      = '0;
      dn_ctrl      = '0;
      clr_cnt_in   = clr_cnt_ff;
      func_in      = func_ff;
      u_lo_in      = u_lo_ff;
      lo_hit_in    = lo_hit_ff;
      hi_hit_in    = hi_hit_ff;
      lo_in        = lo_ff;
      rsp_load     = 1'b0;
      rsp_word_in  = rsp_word_ff;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_up_in    = rsp_up_ff;
      rsp_dn_in    = rsp_dn_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_ctrl   = '{en: 1'b1, we: 1'b1};
            mem_addr   = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               func_in = req_func;
               u_lo_in = req_tex_u[1:0];
               unique case (req_func)
                  FUNC_START_UP:   up_ctrl.start = 1'b1;
                  FUNC_START_DOWN: dn_ctrl.start = 1'b1;
                  FUNC_WRITE: begin
                     if (up_active) begin
                        mem_ctrl        = '{en: 1'b1, we: 1'b1};
                        mem_addr        = {up_row, up_col};
                        up_ctrl.advance = 1'b1;
                     end
                  end
                  FUNC_READ: begin
                     lo_hit_in = dn_active;
                     if (dn_active) begin
                        mem_ctrl        = '{en: 1'b1, we: 1'b0};
                        dn_ctrl.advance = 1'b1;
                     end
                  end
                  FUNC_TEXEL: begin
                     mem_ctrl = '{en: 1'b1, we: 1'b0};
                     mem_addr = {tex_row[ROW_W-1:0], tex_col[COL_W-1:0]};
                  end
                  default: ;
               endcase
            end
         end
         ST_SECOND: begin
            if (func_ff == FUNC_READ) begin
               // lower halfword has landed; fetch the upper one
               lo_in     = lo_hit_ff ? mem_rdata : '0;
               hi_hit_in = dn_active;
               if (dn_active) begin
                  mem_ctrl        = '{en: 1'b1, we: 1'b0};
                  dn_ctrl.advance = 1'b1;
               end
            end else if ((depth_ff == DEPTH_4BPP) || (depth_ff == DEPTH_8BPP)) begin
               mem_ctrl = '{en: 1'b1, we: 1'b0};
               mem_addr = {pal_row[ROW_W-1:0], pal_col[COL_W-1:0]};
            end
         end
         ST_DONE: begin
            rsp_load     = !rsp_valid_ff || rsp_ready;
            rsp_word_in  = '0;
            rsp_red_in   = '0;
            rsp_green_in = '0;
            rsp_blue_in  = '0;
            rsp_up_in    = up_active;
            rsp_dn_in    = dn_active;
            if (func_ff == FUNC_READ) begin
               rsp_word_in = {(hi_hit_ff ? mem_rdata : {HALF_W{1'b0}}), lo_ff};
            end else if (func_ff == FUNC_TEXEL) begin
               // mask bit is dropped by the channel expansion
               rsp_red_in   = {mem_rdata[4:0], 3'b000};
               rsp_green_in = {mem_rdata[9:5], 3'b000};
               rsp_blue_in  = {mem_rdata[14:10], 3'b000};
            end
            if (!rsp_load) begin
               rsp_word_in  = rsp_word_ff;
               rsp_red_in   = rsp_red_ff;
               rsp_green_in = rsp_green_ff;
               rsp_blue_in  = rsp_blue_ff;
               rsp_up_in    = rsp_up_ff;
               rsp_dn_in    = rsp_dn_ff;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         tpx_ff       <= '0;
         tpy_ff       <= '0;
         plx_ff       <= '0;
         ply_ff       <= '0;
         depth_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         tpx_ff       <= tpx_in;
         tpy_ff       <= tpy_in;
         plx_ff       <= plx_in;
         ply_ff       <= ply_in;
         depth_ff     <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      u_lo_ff      <= u_lo_in;
      lo_hit_ff    <= lo_hit_in;
      hi_hit_ff    <= hi_hit_in;
      lo_ff        <= lo_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_up_ff    <= rsp_up_in;
      rsp_dn_ff    <= rsp_dn_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_word     = rsp_word_ff;
   assign rsp_red           = rsp_red_ff;
   assign rsp_green         = rsp_green_ff;
   assign rsp_blue          = rsp_blue_ff;
   assign rsp_upload_busy   = rsp_up_ff;
   assign rsp_download_busy = rsp_dn_ff;

   a_write_needs_upload : assert property (@(posedge clock) disable iff (reset)
      (mem_ctrl.we && (state_ff != ST_CLEAR)) |-> up_active)
      else $error("vram written outside an upload");

   a_no_access_in_done : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> !mem_ctrl.en)
      else $error("memory accessed while the result is being formed");

   a_short_transaction : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func != FUNC_READ) && (req_func != FUNC_TEXEL))
         |=> (state_ff == ST_DONE))
      else $error("single-access transaction did not go straight to the result");

   a_no_result_in_clear : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result shown during the clearing pass");

endmodule

// ===== hw/rtl/vrtf_vram.sv =====
module vrtf_vram
   import vrtf_pkg::*;
#(
   parameter int unsigned ADDR_W = 19
) (
   input  logic              clock,
   input  mem_ctrl_type      ctrl,
   input  logic [ADDR_W-1:0] addr,
   input  logic [HALF_W-1:0] wdata,
   output logic [HALF_W-1:0] rdata
);

   logic [HALF_W-1:0] mem [0:(2**ADDR_W)-1];
   logic [HALF_W-1:0] rdata_ff;

   // single port: read data holds until the next read
   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         if (ctrl.we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/vrtf_cursor.sv =====
module vrtf_cursor
   import vrtf_pkg::*;
#(
   parameter int unsigned VRAM_WIDTH  = 1024,
   parameter int unsigned VRAM_HEIGHT = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cur_ctrl_type                   ctrl,
   input  rect_type                       rect,
   output logic                           active,
   output logic [$clog2(VRAM_WIDTH)-1:0]  col,
   output logic [$clog2(VRAM_HEIGHT)-1:0] row
);

   localparam int unsigned COL_W     = $clog2(VRAM_WIDTH);
   localparam int unsigned ROW_W     = $clog2(VRAM_HEIGHT);
   localparam int unsigned COL_STEPS = COORD_W - COL_W;
   localparam int unsigned ROW_STEPS = COORD_W - ROW_W;

   rect_type     rect_ff, rect_in;
   logic [10:0]  cx_ff, cx_in, cx_inc;
   logic [9:0]   cy_ff, cy_in, cy_inc;
   logic         active_ff, active_in;
   logic [COORD_W-1:0] col_sum, row_sum, col_wrap, row_wrap;

   always_comb begin
      rect_in   = rect_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      active_in = active_ff;
      cx_inc    = cx_ff + 11'd1;
      cy_inc    = cy_ff + 10'd1;
      if (ctrl.start && (rect.w != '0) && (rect.h != '0)) begin
         rect_in   = rect;
         cx_in     = '0;
         cy_in     = '0;
         active_in = 1'b1;
      end else if (ctrl.advance) begin
         if (cx_inc == rect_ff.w) begin
            cx_in = '0;
            if (cy_inc == rect_ff.h) begin
               cy_in     = '0;
               active_in = 1'b0;
            end else begin
               cy_in = cy_inc;
            end
         end else begin
            cx_in = cx_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_ff   <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         active_ff <= 1'b0;
      end else begin
         rect_ff   <= rect_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         active_ff <= active_in;
      end
   end

   assign col_sum  = {2'b00, rect_ff.x} + {1'b0, cx_ff};
   assign row_sum  = {3'b000, rect_ff.y} + {2'b00, cy_ff};
   assign col_wrap = wrap_coord(col_sum, (COORD_W+1)'(VRAM_WIDTH), COL_STEPS);
   assign row_wrap = wrap_coord(row_sum, (COORD_W+1)'(VRAM_HEIGHT), ROW_STEPS);
   assign col      = col_wrap[COL_W-1:0];
   assign row      = row_wrap[ROW_W-1:0];
   assign active   = active_ff;

endmodule
